[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rlrs_pkg.sv]
`timescale 1ns / 1ps

package rlrs_pkg;

   localparam int unsigned HDR_SIZE_DEFAULT = 64;

   localparam logic [31:0] LOG_MAGIC    = 32'h5441_4e53;
   localparam logic [31:0] COMMIT_MAGIC = 32'h5441_4e43;
   localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;
   localparam logic [31:0] CRC_INIT     = 32'hffff_ffff;

   // header bytes covered by the header CRC
   localparam int unsigned HDR_CRC_SPAN = 48;
   localparam int unsigned MARKER_BYTES = 4;

   // byte offset of the last byte of each header field
   localparam int unsigned OFS_MAGIC       = 3;
   localparam int unsigned OFS_VERSION     = 5;
   localparam int unsigned OFS_HDR_LEN     = 7;
   localparam int unsigned OFS_SEQUENCE    = 31;
   localparam int unsigned OFS_PAYLOAD_LEN = 43;
   localparam int unsigned OFS_PAYLOAD_CRC = 47;
   localparam int unsigned OFS_HDR_CRC     = 51;

   localparam int unsigned POS_W  = 33;
   localparam int unsigned SEEN_W = 33;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_STORAGE_CAPACITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT_VERSION   = 2'd2;

   localparam logic [31:0] STORAGE_CAPACITY_RESET = 32'd65536;
   localparam logic [31:0] PAYLOAD_LIMIT_RESET    = 32'd4096;
   localparam logic [15:0] FORMAT_VERSION_RESET   = 16'd1;

   typedef enum logic [1:0] {
      STATUS_CLEAN   = 2'd0,
      STATUS_TORN    = 2'd1,
      STATUS_CORRUPT = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        gap_lost;
      logic [31:0] rec_count;
      logic [63:0] seq_first;
      logic [63:0] seq_last;
      logic [31:0] used_bytes;
   } result_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

[hw/rtl/rlrs_if.sv]
`timescale 1ns / 1ps

interface rlrs_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output has_byte, output data_byte, output last, input ready);
   modport sink   (input valid, input has_byte, input data_byte, input last, output ready);
endinterface

interface rlrs_rsp_if;
   import rlrs_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   logic        gap_lost;
   logic [31:0] rec_count;
   logic [63:0] seq_first;
   logic [63:0] seq_last;
   logic [31:0] used_bytes;

   modport source (output valid, output status, output gap_lost, output rec_count,
                   output seq_first, output seq_last, output used_bytes,
                   input ready);
   modport sink   (input valid, input status, input gap_lost, input rec_count,
                   input seq_first, input seq_last, input used_bytes,
                   output ready);
endinterface

[hw/rtl/record_log_recovery_scanner_unit.sv]
`timescale 1ns / 1ps
// Recovery scanner for a CRC-32 framed record log, fed at most one byte per transaction.
// req_chan: has_byte/data_byte carry the next log byte; last closes the log.
// rsp_chan: one summary per transaction with last set (status, retention gap,
//   record count, low/high sequence, bytes of whole accepted records).
// csr_*: storage capacity, payload limit and format version; write only while
//   the scanner is idle.
// Throughput: one byte per cycle while req_chan.ready is high. The per-byte path is one CRC-32 byte step
//   plus the 33-bit record position add and compare against the record length.
// The summary is registered: rsp_chan.valid is set in the cycle after the closing
//   transaction is accepted when the output register is free.
// The result side has an output register and a skid register, so bytes keep
//   flowing while a summary waits; req_chan.ready drops only when both hold
//   summaries.
// Reset clears the scan state and the result buffer and loads the register
//   defaults (capacity 65536, payload limit 4096, version 1).
// After a summary the scan restarts; register values are kept.
module record_log_recovery_scanner_unit #(
   parameter int unsigned HDR_SIZE = rlrs_pkg::HDR_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   rlrs_req_if.sink                         req_chan,
   rlrs_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_en,
   input  logic [rlrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rlrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rlrs_pkg::*;

`include "assert_macros.svh"

   localparam logic [POS_W-1:0] HdrLen     = POS_W'(HDR_SIZE);
   localparam logic [POS_W-1:0] CommitLen  = POS_W'(MARKER_BYTES);
   localparam logic [POS_W-1:0] HdrGate    = POS_W'(HDR_SIZE + MARKER_BYTES);
   localparam logic [POS_W-1:0] CrcSpan    = POS_W'(HDR_CRC_SPAN);
   localparam logic [POS_W-1:0] OfsMagic   = POS_W'(OFS_MAGIC);
   localparam logic [POS_W-1:0] OfsVersion = POS_W'(OFS_VERSION);
   localparam logic [POS_W-1:0] OfsHdrLen  = POS_W'(OFS_HDR_LEN);
   localparam logic [POS_W-1:0] OfsSeq     = POS_W'(OFS_SEQUENCE);
   localparam logic [POS_W-1:0] OfsPlen    = POS_W'(OFS_PAYLOAD_LEN);
   localparam logic [POS_W-1:0] OfsPcrc    = POS_W'(OFS_PAYLOAD_CRC);
   localparam logic [POS_W-1:0] OfsHcrc    = POS_W'(OFS_HDR_CRC);
   localparam logic [15:0]      HdrLenField = 16'(HDR_SIZE);

   // configuration
   logic [31:0] capacity_ff, plimit_ff;
   logic [15:0] fmt_ver_ff;

   // scan state
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [31:0]       rstart_ff, rstart_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [63:0]       acc_ff, acc_in;
   logic [31:0]       hcrc_ff, hcrc_in;
   logic [31:0]       pcrc_ff, pcrc_in;
   logic              hfault_ff, hfault_in;
   logic [63:0]       seq_ff, seq_in;
   logic [31:0]       plen_ff, plen_in;
   logic [31:0]       exp_crc_ff, exp_crc_in;
   logic [31:0]       commit_ff, commit_in;
   logic [31:0]       cnt_ff, cnt_in;
   logic [63:0]       first_ff, first_in;
   logic [63:0]       latest_ff, latest_in;
   status_type        status_ff, status_in;
   logic              gap_ff, gap_in;
   logic              stopped_ff, stopped_in;

   // result buffer
   logic       rsp_vld_ff, rsp_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   result_type rsp_data_ff, rsp_data_in;
   result_type skid_data_ff, skid_data_in;

   logic             req_fire, take, push, pop, overflow;
   logic [31:0]      w32;
   logic [POS_W-1:0] pend_cur, rlen;
   result_type       res;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign take           = req_fire && req_chan.has_byte && !stopped_ff;
   assign push           = req_fire && req_chan.last;
   assign pop            = rsp_vld_ff && rsp_chan.ready;
   assign req_chan.ready = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= STORAGE_CAPACITY_RESET;
         plimit_ff   <= PAYLOAD_LIMIT_RESET;
         fmt_ver_ff  <= FORMAT_VERSION_RESET;
      end else if (csr_write_en) begin
         priority if (csr_index == CSR_STORAGE_CAPACITY) begin
            capacity_ff <= csr_wdata;
         end else if (csr_index == CSR_PAYLOAD_LIMIT) begin
            plimit_ff <= csr_wdata;
         end else if (csr_index == CSR_FORMAT_VERSION) begin
            fmt_ver_ff <= csr_wdata[15:0];
         end else begin
            // unmapped index: dropped
         end
      end
   end

   always_comb begin
      seen_in    = seen_ff;
      rstart_in  = rstart_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      hcrc_in    = hcrc_ff;
      pcrc_in    = pcrc_ff;
      hfault_in  = hfault_ff;
      seq_in     = seq_ff;
      plen_in    = plen_ff;
      exp_crc_in = exp_crc_ff;
      commit_in  = commit_ff;
      cnt_in     = cnt_ff;
      first_in   = first_ff;
      latest_in  = latest_ff;
      status_in  = status_ff;
      gap_in     = gap_ff;
      stopped_in = stopped_ff;
      w32        = '0;
      pend_cur   = HdrLen + {1'b0, plen_ff};
      rlen       = '0;

      // byte counter saturates at 2^32
      if (req_fire && req_chan.has_byte && !seen_ff[SEEN_W-1]) begin
         seen_in = seen_ff + SEEN_W'(1);
      end

      if (take) begin
         if (pos_ff < HdrLen) begin
            acc_in = {req_chan.data_byte, acc_ff[63:8]};
            w32    = acc_in[63:32];
            if (pos_ff < CrcSpan) begin
               hcrc_in = crc32_byte(hcrc_ff, req_chan.data_byte);
            end
            if (pos_ff == OfsMagic && w32 != LOG_MAGIC) begin
               hfault_in = 1'b1;
            end
            if (pos_ff == OfsVersion && acc_in[63:48] != fmt_ver_ff) begin
               hfault_in = 1'b1;
            end
            if (pos_ff == OfsHdrLen && acc_in[63:48] != HdrLenField) begin
               hfault_in = 1'b1;
            end
            if (pos_ff == OfsSeq) begin
               seq_in = acc_in;
            end
            if (pos_ff == OfsPlen) begin
               plen_in = w32;
               if (w32 > plimit_ff) begin
                  hfault_in = 1'b1;
               end
            end
            if (pos_ff == OfsPcrc) begin
               exp_crc_in = w32;
            end
            if (pos_ff == OfsHcrc && w32 != ~hcrc_ff) begin
               hfault_in = 1'b1;
            end
         end else if (pos_ff < pend_cur) begin
            pcrc_in = crc32_byte(pcrc_ff, req_chan.data_byte);
         end else begin
            commit_in = {req_chan.data_byte, commit_ff[31:8]};
         end

         pos_in = pos_ff + POS_W'(1);
         rlen   = HdrLen + {1'b0, plen_in} + CommitLen;

         // header faults only count once the header and a commit's worth are in
         if (pos_in == HdrGate && hfault_in) begin
            status_in  = STATUS_CORRUPT;
            gap_in     = 1'b1;
            stopped_in = 1'b1;
         end else if (pos_in == rlen) begin
            if (commit_in != COMMIT_MAGIC) begin
               status_in  = STATUS_TORN;
               stopped_in = 1'b1;
            end else if (~pcrc_in != exp_crc_in || (cnt_ff != '0 && seq_in <= latest_ff)) begin
               status_in  = STATUS_CORRUPT;
               gap_in     = 1'b1;
               stopped_in = 1'b1;
            end else begin
               if (cnt_ff == '0) begin
                  first_in = seq_in;
               end
               latest_in  = seq_in;
               cnt_in     = cnt_ff + 32'd1;
               rstart_in  = rstart_ff + rlen[31:0];
               pos_in     = '0;
               acc_in     = '0;
               hcrc_in    = CRC_INIT;
               pcrc_in    = CRC_INIT;
               hfault_in  = 1'b0;
               seq_in     = '0;
               plen_in    = '0;
               exp_crc_in = '0;
               commit_in  = '0;
            end
         end
      end

      overflow = seen_in > {1'b0, capacity_ff};
      if (overflow) begin
         res = '{status: STATUS_CORRUPT, gap_lost: 1'b1, rec_count: '0,
                 seq_first: '0, seq_last: '0, used_bytes: '0};
      end else begin
         res.status     = (!stopped_in && pos_in != '0) ? STATUS_TORN : status_in;
         res.gap_lost   = gap_in;
         res.rec_count  = cnt_in;
         res.seq_first  = first_in;
         res.seq_last   = latest_in;
         res.used_bytes = rstart_in;
      end

      // closing transaction: the scan starts over
      if (push) begin
         seen_in    = '0;
         rstart_in  = '0;
         pos_in     = '0;
         acc_in     = '0;
         hcrc_in    = CRC_INIT;
         pcrc_in    = CRC_INIT;
         hfault_in  = 1'b0;
         seq_in     = '0;
         plen_in    = '0;
         exp_crc_in = '0;
         commit_in  = '0;
         cnt_in     = '0;
         first_in   = '0;
         latest_in  = '0;
         status_in  = STATUS_CLEAN;
         gap_in     = 1'b0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         rstart_ff  <= '0;
         pos_ff     <= '0;
         acc_ff     <= '0;
         hcrc_ff    <= CRC_INIT;
         pcrc_ff    <= CRC_INIT;
         hfault_ff  <= 1'b0;
         seq_ff     <= '0;
         plen_ff    <= '0;
         exp_crc_ff <= '0;
         commit_ff  <= '0;
         cnt_ff     <= '0;
         first_ff   <= '0;
         latest_ff  <= '0;
         status_ff  <= STATUS_CLEAN;
         gap_ff     <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         seen_ff    <= seen_in;
         rstart_ff  <= rstart_in;
         pos_ff     <= pos_in;
         acc_ff     <= acc_in;
         hcrc_ff    <= hcrc_in;
         pcrc_ff    <= pcrc_in;
         hfault_ff  <= hfault_in;
         seq_ff     <= seq_in;
         plen_ff    <= plen_in;
         exp_crc_ff <= exp_crc_in;
         commit_ff  <= commit_in;
         cnt_ff     <= cnt_in;
         first_ff   <= first_in;
         latest_ff  <= latest_in;
         status_ff  <= status_in;
         gap_ff     <= gap_in;
         stopped_ff <= stopped_in;
      end
   end

   // output register plus skid register
   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      skid_vld_in  = skid_vld_ff;
      rsp_data_in  = rsp_data_ff;
      skid_data_in = skid_data_ff;
      if (!rsp_vld_ff || pop) begin
         if (skid_vld_ff) begin
            rsp_data_in = skid_data_ff;
            rsp_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            rsp_vld_in = push;
            if (push) begin
               rsp_data_in = res;
            end
         end
      end else if (push) begin
         skid_vld_in  = 1'b1;
         skid_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.status     = rsp_data_ff.status;
   assign rsp_chan.gap_lost   = rsp_data_ff.gap_lost;
   assign rsp_chan.rec_count  = rsp_data_ff.rec_count;
   assign rsp_chan.seq_first  = rsp_data_ff.seq_first;
   assign rsp_chan.seq_last   = rsp_data_ff.seq_last;
   assign rsp_chan.used_bytes = rsp_data_ff.used_bytes;

   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, skid_vld_ff |-> rsp_vld_ff, "skid without output")
   `ASSERT_NEXT(a_close_gives_rsp, clock, reset, push, rsp_vld_ff, "closing transaction left no summary")
   `ASSERT_NEXT(a_close_restarts, clock, reset, push, pos_ff == '0 && !stopped_ff && cnt_ff == '0 && seen_ff == '0, "scan not cleared")
   `ASSERT_ALWAYS(a_stop_has_status, clock, reset, stopped_ff |-> status_ff != STATUS_CLEAN, "stopped while clean")
   `ASSERT_ALWAYS(a_gap_is_corrupt, clock, reset, (rsp_vld_ff && rsp_data_ff.gap_lost) |-> rsp_data_ff.status == STATUS_CORRUPT, "gap without corrupt")

endmodule
